### hw/rtl/stp_pkg.sv
// section timing profiler: shared constants, codes, record and control types
// used by stp_div, stp_dpath, stp_ctrl and section_timing_profiler_core
// no dependencies
package stp_pkg;

	localparam int unsigned SECTIONS   = 64;
	localparam int unsigned SEC_AW     = (SECTIONS > 1) ? $clog2(SECTIONS) : 1;
	localparam int unsigned SECTION_W  = 6;
	localparam int unsigned STAMP_W    = 64;
	localparam int unsigned COUNT_W    = 32;
	localparam int unsigned CMD_W      = 2;
	localparam int unsigned STATUS_W   = 2;
	localparam int unsigned IN_TDATA_W  = ((SECTION_W + STAMP_W + 7) / 8) * 8;
	localparam int unsigned OUT_TDATA_W = 4 * STAMP_W + COUNT_W;
	localparam int unsigned DIV_CNT_W   = $clog2(STAMP_W + 1);

	localparam logic [STAMP_W-1:0] ALL_ONES   = {STAMP_W{1'b1}};
	localparam logic [COUNT_W-1:0] TRIM_CALLS = COUNT_W'(4);

	typedef enum logic [CMD_W-1:0] {
		CMD_BEGIN = 2'd0,
		CMD_END   = 2'd1,
		CMD_READ  = 2'd2,
		CMD_NONE  = 2'd3
	} stp_op_t;

	typedef enum logic [STATUS_W-1:0] {
		STS_OK     = 2'd0,
		STS_UNUSED = 2'd1,
		STS_FEW    = 2'd2
	} stp_status_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_UPD,
		ST_TRIM,
		ST_DSTART,
		ST_DIV
	} stp_state_t;

	// one profiling record, kept per section in the record memory
	typedef struct packed {
		logic [STAMP_W-1:0] start_stamp;
		logic [STAMP_W-1:0] sum_ticks;
		logic [STAMP_W-1:0] least_first;
		logic [STAMP_W-1:0] least_second;
		logic [STAMP_W-1:0] most_first;
		logic [STAMP_W-1:0] most_second;
		logic [COUNT_W-1:0] begin_count;
	} stp_rec_t;

	// controller to datapath
	typedef struct packed {
		logic       accept;
		logic       begin_wr;
		logic       diff_ld;
		logic       end_wr;
		logic       out_simple;
		logic       trim_ld;
		logic       trim_step;
		logic [1:0] trim_sel;
		logic       div_start;
		logic       out_avg;
	} stp_cmd_t;

	// datapath to controller
	typedef struct packed {
		stp_op_t op;
		logic    used;
		logic    few;
		logic    out_free;
		logic    div_busy;
	} stp_sts_t;

endpackage

### hw/rtl/stp_div.sv
// restoring divider, one quotient bit per cycle, for the trimmed average
// depends on stp_pkg
module stp_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [stp_pkg::STAMP_W-1:0]   dividend,
	input  logic [stp_pkg::COUNT_W-1:0]   divisor,
	output logic                          busy,
	output logic [stp_pkg::STAMP_W-1:0]   quotient
);

	logic                             busy_q;
	logic [stp_pkg::DIV_CNT_W-1:0]    cnt_q;
	logic [stp_pkg::COUNT_W-1:0]      rem_q;
	logic [stp_pkg::STAMP_W-1:0]      quo_q;
	logic [stp_pkg::COUNT_W-1:0]      den_q;
	logic [stp_pkg::COUNT_W:0]        trial;
	logic [stp_pkg::COUNT_W:0]        diff;
	logic                             fits;

	assign trial = {rem_q, quo_q[stp_pkg::STAMP_W-1]};
	assign fits  = trial >= {1'b0, den_q};
	assign diff  = trial - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= stp_pkg::DIV_CNT_W'(stp_pkg::STAMP_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == stp_pkg::DIV_CNT_W'(1))
				busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			den_q <= divisor;
		end else if (busy_q) begin
			// remainder stays below the divisor, so its low bits are enough
			rem_q <= fits ? diff[stp_pkg::COUNT_W-1:0] : trial[stp_pkg::COUNT_W-1:0];
			quo_q <= {quo_q[stp_pkg::STAMP_W-2:0], fits};
		end
	end

	assign busy     = busy_q;
	assign quotient = quo_q;

endmodule

### hw/rtl/stp_dpath.sv
// datapath: item registers, record memory, section-used flags, duration
// update, trimmed sum, divider and output register; depends on stp_pkg, stp_div
module stp_dpath (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic [stp_pkg::IN_TDATA_W-1:0]    in_tdata,
	input  logic [stp_pkg::CMD_W-1:0]         in_tuser,
	input  stp_pkg::stp_cmd_t                 cmd,
	output stp_pkg::stp_sts_t                 sts,
	output logic                              out_tvalid,
	input  logic                              out_tready,
	output logic [stp_pkg::OUT_TDATA_W-1:0]   out_tdata,
	output logic [stp_pkg::STATUS_W-1:0]      out_tuser
);

	logic [stp_pkg::SECTION_W-1:0]    in_sec;
	logic [stp_pkg::STAMP_W-1:0]      in_ts;

	stp_pkg::stp_op_t                 op_q;
	logic [stp_pkg::SECTION_W-1:0]    sec_q;
	logic [stp_pkg::STAMP_W-1:0]      ts_q;
	stp_pkg::stp_rec_t                rec_q;
	logic [stp_pkg::STAMP_W-1:0]      d_q;
	logic [stp_pkg::STAMP_W-1:0]      trim_q;
	logic [stp_pkg::SECTIONS-1:0]     used_q;
	logic                             out_valid_q;
	logic [stp_pkg::OUT_TDATA_W-1:0]  out_tdata_q;
	logic [stp_pkg::STATUS_W-1:0]     out_tuser_q;

	stp_pkg::stp_rec_t                rec_mem [stp_pkg::SECTIONS];

	logic [stp_pkg::SEC_AW-1:0]       rd_addr;
	logic [stp_pkg::SEC_AW-1:0]       addr_q;
	logic                             sec_ok;
	logic                             used;
	logic                             few;
	stp_pkg::stp_rec_t                begin_rec;
	stp_pkg::stp_rec_t                end_rec;
	stp_pkg::stp_rec_t                wr_rec;
	logic                             wr_en;
	logic [stp_pkg::STAMP_W-1:0]      trim_op;
	logic                             div_busy;
	logic [stp_pkg::STAMP_W-1:0]      quotient;
	logic [stp_pkg::COUNT_W-1:0]      divisor;
	logic                             out_free;
	logic                             out_load;
	logic [stp_pkg::STATUS_W-1:0]     res_status;
	logic [stp_pkg::OUT_TDATA_W-1:0]  res_data;

	assign in_sec  = in_tdata[stp_pkg::SECTION_W-1:0];
	assign in_ts   = in_tdata[stp_pkg::SECTION_W +: stp_pkg::STAMP_W];
	assign rd_addr = stp_pkg::SEC_AW'(in_sec);
	assign addr_q  = stp_pkg::SEC_AW'(sec_q);

	assign sec_ok = 32'(sec_q) < stp_pkg::SECTIONS;
	assign used   = sec_ok && used_q[addr_q];
	assign few    = rec_q.begin_count <= stp_pkg::TRIM_CALLS;

	// item capture and record read in the transfer cycle
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			op_q  <= stp_pkg::stp_op_t'(in_tuser);
			sec_q <= in_sec;
			ts_q  <= in_ts;
			rec_q <= rec_mem[rd_addr];
		end
		if (wr_en)
			rec_mem[addr_q] <= wr_rec;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			used_q <= '0;
		else if (cmd.begin_wr && sec_ok)
			used_q[addr_q] <= 1'b1;
	end

	// begin: fresh record on first call, else restamp and count
	always_comb begin
		begin_rec = rec_q;
		begin_rec.start_stamp = ts_q;
		if (!used) begin
			begin_rec.sum_ticks    = '0;
			begin_rec.least_first  = stp_pkg::ALL_ONES;
			begin_rec.least_second = stp_pkg::ALL_ONES;
			begin_rec.most_first   = '0;
			begin_rec.most_second  = '0;
			begin_rec.begin_count  = stp_pkg::COUNT_W'(1);
		end else begin
			begin_rec.begin_count = rec_q.begin_count + 1'b1;
		end
	end

	// end: accumulate and keep two largest and two smallest durations
	always_comb begin
		end_rec = rec_q;
		end_rec.sum_ticks = rec_q.sum_ticks + d_q;
		if (d_q > rec_q.most_second) begin
			if (d_q > rec_q.most_first) begin
				end_rec.most_second = rec_q.most_first;
				end_rec.most_first  = d_q;
			end else begin
				end_rec.most_second = d_q;
			end
		end
		if (d_q < rec_q.least_second) begin
			if (d_q < rec_q.least_first) begin
				end_rec.least_second = rec_q.least_first;
				end_rec.least_first  = d_q;
			end else begin
				end_rec.least_second = d_q;
			end
		end
	end

	assign wr_en  = (cmd.begin_wr && sec_ok) || cmd.end_wr;
	assign wr_rec = cmd.begin_wr ? begin_rec : end_rec;

	always_ff @(posedge clk) begin
		if (cmd.diff_ld)
			d_q <= ts_q - rec_q.start_stamp;
	end

	// trimmed sum, one saturating subtract per cycle
	always_comb begin
		case (cmd.trim_sel)
			2'd0:    trim_op = rec_q.least_first;
			2'd1:    trim_op = rec_q.least_second;
			2'd2:    trim_op = rec_q.most_first;
			2'd3:    trim_op = rec_q.most_second;
			default: trim_op = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.trim_ld)
			trim_q <= rec_q.sum_ticks;
		else if (cmd.trim_step)
			trim_q <= (trim_q >= trim_op) ? trim_q - trim_op : '0;
	end

	assign divisor = rec_q.begin_count - stp_pkg::TRIM_CALLS;

	stp_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (trim_q),
		.divisor  (divisor),
		.busy     (div_busy),
		.quotient (quotient)
	);

	// result assembly
	always_comb begin
		res_status = stp_pkg::STS_OK;
		res_data   = '0;
		if (cmd.out_avg) begin
			res_data = {quotient, rec_q.begin_count, rec_q.most_first,
				rec_q.least_first, rec_q.sum_ticks};
		end else begin
			case (op_q)
				stp_pkg::CMD_BEGIN: res_status = stp_pkg::STS_OK;
				stp_pkg::CMD_END:
					res_status = used ? stp_pkg::STS_OK : stp_pkg::STS_UNUSED;
				stp_pkg::CMD_READ: begin
					if (!used) begin
						res_status = stp_pkg::STS_UNUSED;
					end else begin
						res_status = stp_pkg::STS_FEW;
						res_data   = {{stp_pkg::STAMP_W{1'b0}}, rec_q.begin_count,
							rec_q.most_first, rec_q.least_first, rec_q.sum_ticks};
					end
				end
				default: res_status = stp_pkg::STS_OK;
			endcase
		end
	end

	assign out_free = !out_valid_q || out_tready;
	assign out_load = cmd.out_simple || cmd.out_avg;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (out_load)
			out_valid_q <= 1'b1;
		else if (out_tready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_tdata_q <= res_data;
			out_tuser_q <= res_status;
		end
	end

	assign sts.op       = op_q;
	assign sts.used     = used;
	assign sts.few      = few;
	assign sts.out_free = out_free;
	assign sts.div_busy = div_busy;

	assign out_tvalid = out_valid_q;
	assign out_tdata  = out_tdata_q;
	assign out_tuser  = out_tuser_q;

endmodule

### hw/rtl/stp_ctrl.sv
// controller: sequences one item through record read, update or trim and
// divide, and result load; depends on stp_pkg
module stp_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  stp_pkg::stp_sts_t    sts,
	output stp_pkg::stp_cmd_t    cmd
);

	stp_pkg::stp_state_t  state_q;
	stp_pkg::stp_state_t  state_d;
	logic [1:0]           trim_cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= stp_pkg::ST_IDLE;
			trim_cnt_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == stp_pkg::ST_TRIM)
				trim_cnt_q <= trim_cnt_q + 1'b1;
			else
				trim_cnt_q <= '0;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			stp_pkg::ST_IDLE:
				if (in_valid)
					state_d = stp_pkg::ST_EXEC;
			stp_pkg::ST_EXEC: begin
				case (sts.op)
					stp_pkg::CMD_END:
						if (sts.used)
							state_d = stp_pkg::ST_UPD;
						else if (sts.out_free)
							state_d = stp_pkg::ST_IDLE;
					stp_pkg::CMD_READ:
						if (sts.used && !sts.few)
							state_d = stp_pkg::ST_TRIM;
						else if (sts.out_free)
							state_d = stp_pkg::ST_IDLE;
					default:
						if (sts.out_free)
							state_d = stp_pkg::ST_IDLE;
				endcase
			end
			stp_pkg::ST_UPD:
				if (sts.out_free)
					state_d = stp_pkg::ST_IDLE;
			stp_pkg::ST_TRIM:
				if (trim_cnt_q == 2'd3)
					state_d = stp_pkg::ST_DSTART;
			stp_pkg::ST_DSTART:
				state_d = stp_pkg::ST_DIV;
			stp_pkg::ST_DIV:
				if (!sts.div_busy && sts.out_free)
					state_d = stp_pkg::ST_IDLE;
			default:
				state_d = stp_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			stp_pkg::ST_IDLE: begin
				in_ready   = 1'b1;
				cmd.accept = in_valid;
			end
			stp_pkg::ST_EXEC: begin
				case (sts.op)
					stp_pkg::CMD_BEGIN: begin
						cmd.begin_wr   = sts.out_free;
						cmd.out_simple = sts.out_free;
					end
					stp_pkg::CMD_END: begin
						cmd.diff_ld    = sts.used;
						cmd.out_simple = !sts.used && sts.out_free;
					end
					stp_pkg::CMD_READ: begin
						cmd.trim_ld    = sts.used && !sts.few;
						cmd.out_simple = !(sts.used && !sts.few) && sts.out_free;
					end
					default:
						cmd.out_simple = sts.out_free;
				endcase
			end
			stp_pkg::ST_UPD: begin
				cmd.end_wr     = sts.out_free;
				cmd.out_simple = sts.out_free;
			end
			stp_pkg::ST_TRIM: begin
				cmd.trim_step = 1'b1;
				cmd.trim_sel  = trim_cnt_q;
			end
			stp_pkg::ST_DSTART:
				cmd.div_start = 1'b1;
			stp_pkg::ST_DIV:
				cmd.out_avg = !sts.div_busy && sts.out_free;
			default: begin
				cmd      = '0;
				in_ready = 1'b0;
			end
		endcase
	end

endmodule

### hw/rtl/section_timing_profiler_core.sv
// channel   dir  tdata                          tuser
// s_axis    in   section, timestamp (72 bits)   command (2 bits)
// m_axis    out  total, shortest, longest,      status (2 bits)
//                call_count, trimmed_average
// one item in work at a time; begin, read without average, unused section and
// unknown command go through transfer and an execute step; end goes through record read,
// duration and record write; a read with an average goes through transfer, record
// read, four trim steps, divider start, 64 one-bit divider steps and the result load
// a new item is taken while a result waits; an item stalls in its last step only
// while the output register is still full; reset clears used flags and control
// top level: section timing profiler; depends on stp_pkg, stp_ctrl, stp_dpath
module section_timing_profiler_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	// section [5:0], timestamp [69:6], zero pad [71:70]
	input  logic [stp_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
	// command [1:0]
	input  logic [stp_pkg::CMD_W-1:0]         s_axis_tuser,
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// total_time [63:0], shortest_time [127:64], longest_time [191:128],
	// call_count [223:192], trimmed_average [287:224]
	output logic [stp_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
	// status [1:0]
	output logic [stp_pkg::STATUS_W-1:0]      m_axis_tuser
);

	stp_pkg::stp_cmd_t  cmd;
	stp_pkg::stp_sts_t  sts;

	stp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	stp_dpath u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_tdata   (s_axis_tdata),
		.in_tuser   (s_axis_tuser),
		.cmd        (cmd),
		.sts        (sts),
		.out_tvalid (m_axis_tvalid),
		.out_tready (m_axis_tready),
		.out_tdata  (m_axis_tdata),
		.out_tuser  (m_axis_tuser)
	);

`ifndef SYNTHESIS
	// one item at a time: no transfer right after one
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input taken while an item is in work");

	// a result is loaded only when the output register can take it
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.out_simple || cmd.out_avg) |-> sts.out_free)
		else $error("result register overwritten");

	// the divider runs only while no input is taken
	a_div_idle_in: assert property (@(posedge clk) disable iff (!arst_n)
		sts.div_busy |-> !s_axis_tready)
		else $error("input ready during division");

	// a record write always comes with its result
	a_wr_result: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.begin_wr || cmd.end_wr) |-> cmd.out_simple)
		else $error("record written without a result");
`endif

endmodule

### dv/tb_top.sv
// testbench for section_timing_profiler_core: directed table, then random begin/end/read/unknown
// command traffic checked transfer by transfer against a behavioral profiler model
// depends on stp_pkg and section_timing_profiler_core
`timescale 1ns / 100ps

module tb_top;
	import stp_pkg::*;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [STAMP_W-1:0]  total;
		logic [STAMP_W-1:0]  shortest;
		logic [STAMP_W-1:0]  longest;
		logic [COUNT_W-1:0]  calls;
		logic [STAMP_W-1:0]  average;
	} profile_result_t;

	typedef struct {
		stp_op_t          op;
		logic [5:0]       sec;
		logic [63:0]      ts;
		bit               typed;
		profile_result_t  want;
	} stim_row_t;

	localparam int N_ROWS = 25;
	localparam int N_RANDOM = 700;
	localparam int LONG_HOLD = 400;

	logic clk;
	logic arst_n;
	logic s_axis_tvalid;
	logic s_axis_tready;
	logic [IN_TDATA_W-1:0] s_axis_tdata;
	logic [CMD_W-1:0] s_axis_tuser;
	logic m_axis_tvalid;
	logic m_axis_tready;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;
	logic [STATUS_W-1:0] m_axis_tuser;

	// profiler model state
	bit              rec_used  [SECTIONS];
	logic [63:0]     rec_start [SECTIONS];
	logic [63:0]     rec_sum   [SECTIONS];
	logic [63:0]     rec_lo1   [SECTIONS];
	logic [63:0]     rec_lo2   [SECTIONS];
	logic [63:0]     rec_hi1   [SECTIONS];
	logic [63:0]     rec_hi2   [SECTIONS];
	logic [31:0]     rec_calls [SECTIONS];

	profile_result_t expected_results[$];
	int              error_count = 0;
	int              accepted_items = 0;
	bit              cur_typed;
	profile_result_t cur_want;
	stim_row_t       rows [N_ROWS];

	section_timing_profiler_core u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	initial clk = 1'b0;
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	initial begin
		#10_000_000;
		$display("Test completed with failures");
		$finish;
	end

	initial begin
		for (int i = 0; i < SECTIONS; i++) begin
			rec_used[i] = 1'b0;
			rec_start[i] = '0;
			rec_sum[i] = '0;
			rec_lo1[i] = '0;
			rec_lo2[i] = '0;
			rec_hi1[i] = '0;
			rec_hi2[i] = '0;
			rec_calls[i] = '0;
		end
	end

	task automatic profile_step(input logic [1:0] cmd, input logic [5:0] sec,
			input logic [63:0] ts, output profile_result_t r);
		logic [63:0] d;
		logic [63:0] t;
		bit          in_range;
		bit          used;
		in_range = (sec < SECTIONS);
		used = in_range && rec_used[sec];
		r = '0;
		case (cmd)
			CMD_BEGIN: begin
				if (in_range) begin
					rec_start[sec] = ts;
					if (!rec_used[sec]) begin
						rec_used[sec] = 1'b1;
						rec_sum[sec] = '0;
						rec_lo1[sec] = ALL_ONES;
						rec_lo2[sec] = ALL_ONES;
						rec_hi1[sec] = '0;
						rec_hi2[sec] = '0;
						rec_calls[sec] = 32'd1;
					end else begin
						rec_calls[sec] = rec_calls[sec] + 32'd1;
					end
				end
			end
			CMD_END: begin
				if (!used) begin
					r.status = STS_UNUSED;
				end else begin
					d = ts - rec_start[sec];
					rec_sum[sec] = rec_sum[sec] + d;
					if (d > rec_hi2[sec]) begin
						if (d > rec_hi1[sec]) begin
							rec_hi2[sec] = rec_hi1[sec];
							rec_hi1[sec] = d;
						end else begin
							rec_hi2[sec] = d;
						end
					end
					if (d < rec_lo2[sec]) begin
						if (d < rec_lo1[sec]) begin
							rec_lo2[sec] = rec_lo1[sec];
							rec_lo1[sec] = d;
						end else begin
							rec_lo2[sec] = d;
						end
					end
				end
			end
			CMD_READ: begin
				if (!used) begin
					r.status = STS_UNUSED;
				end else begin
					r.total = rec_sum[sec];
					r.shortest = rec_lo1[sec];
					r.longest = rec_hi1[sec];
					r.calls = rec_calls[sec];
					if (rec_calls[sec] <= TRIM_CALLS) begin
						r.status = STS_FEW;
					end else begin
						// each trim step saturates at zero
						t = rec_sum[sec];
						t = (t >= rec_lo1[sec]) ? t - rec_lo1[sec] : '0;
						t = (t >= rec_lo2[sec]) ? t - rec_lo2[sec] : '0;
						t = (t >= rec_hi1[sec]) ? t - rec_hi1[sec] : '0;
						t = (t >= rec_hi2[sec]) ? t - rec_hi2[sec] : '0;
						r.average = t / {32'd0, rec_calls[sec] - TRIM_CALLS};
						r.status = STS_OK;
					end
				end
			end
			default: r = '0;
		endcase
	endtask

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		$display("%0t mismatch %s: got %h expected %h", $realtime, what, got, want);
		error_count++;
	endtask

	// input transfers feed the model, output transfers are checked against the oldest entry
	always @(posedge clk) begin
		profile_result_t r;
		profile_result_t want;
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready) begin
				profile_step(s_axis_tuser, s_axis_tdata[5:0], s_axis_tdata[69:6], r);
				if (cur_typed)
					r = cur_want;
				expected_results.push_back(r);
				accepted_items++;
			end
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_results.size() == 0) begin
					report_mismatch("result with nothing expected", m_axis_tuser, '0);
				end else begin
					want = expected_results.pop_front();
					if (m_axis_tuser !== want.status)
						report_mismatch("status", m_axis_tuser, want.status);
					if (m_axis_tdata[63:0] !== want.total)
						report_mismatch("total_time", m_axis_tdata[63:0], want.total);
					if (m_axis_tdata[127:64] !== want.shortest)
						report_mismatch("shortest_time", m_axis_tdata[127:64], want.shortest);
					if (m_axis_tdata[191:128] !== want.longest)
						report_mismatch("longest_time", m_axis_tdata[191:128], want.longest);
					if (m_axis_tdata[223:192] !== want.calls)
						report_mismatch("call_count", m_axis_tdata[223:192], want.calls);
					if (m_axis_tdata[287:224] !== want.average)
						report_mismatch("trimmed_average", m_axis_tdata[287:224], want.average);
				end
			end
		end
	end

	// result side: random ready runs, one long hold once traffic is flowing
	initial begin
		int  run_left;
		int  hold_left;
		bit  hold_done;
		bit  ready_state;
		run_left = 0;
		hold_left = 0;
		hold_done = 1'b0;
		ready_state = 1'b0;
		m_axis_tready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready = 1'b0;
			end else if (!hold_done && accepted_items >= 200) begin
				hold_done = 1'b1;
				hold_left = LONG_HOLD - 1;
				m_axis_tready = 1'b0;
			end else begin
				if (run_left == 0) begin
					case ($urandom_range(0, 9))
						0, 1, 2:    begin ready_state = 1'b0; run_left = $urandom_range(1, 4); end
						3:          begin ready_state = 1'b0; run_left = $urandom_range(15, 60); end
						4:          begin ready_state = 1'b1; run_left = $urandom_range(80, 200); end
						default:    begin ready_state = 1'b1; run_left = $urandom_range(1, 8); end
					endcase
				end
				run_left--;
				m_axis_tready = ready_state;
			end
		end
	end

	function automatic stim_row_t mk(stp_op_t op, logic [5:0] sec, logic [63:0] ts);
		stim_row_t row;
		row.op = op;
		row.sec = sec;
		row.ts = ts;
		row.typed = 1'b0;
		row.want = '0;
		return row;
	endfunction

	function automatic stim_row_t mkr(stp_op_t op, logic [5:0] sec, logic [63:0] ts,
			stp_status_t status, logic [63:0] total, logic [63:0] shortest,
			logic [63:0] longest, logic [31:0] calls);
		stim_row_t row;
		row = mk(op, sec, ts);
		row.typed = 1'b1;
		row.want.status = status;
		row.want.total = total;
		row.want.shortest = shortest;
		row.want.longest = longest;
		row.want.calls = calls;
		row.want.average = '0;
		return row;
	endfunction

	// offer one item from a falling edge and hold it until the transfer
	task automatic send_item(input logic [1:0] cmd, input logic [5:0] sec,
			input logic [63:0] ts, input bit typed, input profile_result_t want);
		cur_typed = typed;
		cur_want = want;
		s_axis_tuser = cmd;
		s_axis_tdata = {2'b00, ts, sec};
		s_axis_tvalid = 1'b1;
		do
			@(posedge clk);
		while (!s_axis_tready);
		@(negedge clk);
	endtask

	task automatic idle_gap(input bool_force_zero);
		int g;
		g = 0;
		if (!bool_force_zero) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4, 5: g = 0;
				6, 7, 8:          g = $urandom_range(1, 3);
				default:          g = $urandom_range(5, 40);
			endcase
		end
		if (g > 0) begin
			s_axis_tvalid = 1'b0;
			repeat (g) @(negedge clk);
		end
	endtask

	initial begin
		logic [63:0] tick_now;
		logic [1:0]  cmd;
		logic [5:0]  sec;
		logic [63:0] ts;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = CMD_NONE;
		cur_typed = 1'b0;
		cur_want = '0;
		tick_now = 64'd1000;
		arst_n = 1'b0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		rows[0]  = mkr(CMD_READ,  6'd5,  64'd0,    STS_UNUSED, 0, 0, 0, 0);
		rows[1]  = mkr(CMD_END,   6'd5,  ALL_ONES, STS_UNUSED, 0, 0, 0, 0);
		rows[2]  = mkr(CMD_NONE,  6'd63, ALL_ONES, STS_OK, 0, 0, 0, 0);
		rows[3]  = mkr(CMD_BEGIN, 6'd0,  64'd0,    STS_OK, 0, 0, 0, 0);
		// fresh record: minima all ones, one call
		rows[4]  = mkr(CMD_READ,  6'd0,  64'd0,    STS_FEW, 0, ALL_ONES, 0, 1);
		rows[5]  = mkr(CMD_END,   6'd0,  ALL_ONES, STS_OK, 0, 0, 0, 0);
		rows[6]  = mkr(CMD_BEGIN, 6'd0,  ALL_ONES, STS_OK, 0, 0, 0, 0);
		// duration wraps through zero
		rows[7]  = mkr(CMD_END,   6'd0,  64'd5,    STS_OK, 0, 0, 0, 0);
		rows[8]  = mk(CMD_READ,   6'd0,  64'd0);
		rows[9]  = mkr(CMD_BEGIN, 6'd0,  64'd100,  STS_OK, 0, 0, 0, 0);
		rows[10] = mkr(CMD_END,   6'd0,  64'd110,  STS_OK, 0, 0, 0, 0);
		rows[11] = mkr(CMD_BEGIN, 6'd0,  64'd200,  STS_OK, 0, 0, 0, 0);
		rows[12] = mkr(CMD_END,   6'd0,  64'd203,  STS_OK, 0, 0, 0, 0);
		rows[13] = mkr(CMD_BEGIN, 6'd0,  64'd300,  STS_OK, 0, 0, 0, 0);
		rows[14] = mkr(CMD_END,   6'd0,  64'd1000, STS_OK, 0, 0, 0, 0);
		// sum wrapped, trim saturates
		rows[15] = mk(CMD_READ,   6'd0,  64'd0);
		rows[16] = mkr(CMD_BEGIN, 6'd63, ALL_ONES, STS_OK, 0, 0, 0, 0);
		rows[17] = mkr(CMD_END,   6'd63, ALL_ONES, STS_OK, 0, 0, 0, 0);
		rows[18] = mkr(CMD_READ,  6'd63, 64'd0,    STS_FEW, 0, 0, 0, 1);
		// begins with no ends at all
		for (int i = 19; i < 24; i++)
			rows[i] = mkr(CMD_BEGIN, 6'd1, 64'd42, STS_OK, 0, 0, 0, 0);
		rows[24] = mk(CMD_READ,   6'd1,  64'd0);

		foreach (rows[i]) begin
			send_item(rows[i].op, rows[i].sec, rows[i].ts, rows[i].typed, rows[i].want);
			idle_gap(1'b0);
		end

		for (int n = 0; n < N_RANDOM; n++) begin
			case ($urandom_range(0, 19))
				0, 1, 2, 3, 4, 5, 6, 7, 8:    cmd = CMD_BEGIN;
				9, 10, 11, 12, 13, 14, 15, 16: cmd = CMD_END;
				17, 18:                       cmd = CMD_READ;
				default:                      cmd = CMD_NONE;
			endcase
			if ($urandom_range(0, 9) < 8)
				sec = 6'($urandom_range(0, 7));
			else
				sec = 6'($urandom_range(0, 63));
			tick_now = tick_now + 64'($urandom_range(1, 2000));
			if ($urandom_range(0, 19) == 0)
				ts = {$urandom, $urandom};
			else
				ts = tick_now;
			if (n == 350) begin
				// let the block drain completely before going on
				s_axis_tvalid = 1'b0;
				while (expected_results.size() != 0)
					@(negedge clk);
			end
			send_item(cmd, sec, ts, 1'b0, '0);
			idle_gap(n >= 500 && n < 600);
		end
		s_axis_tvalid = 1'b0;
		cur_typed = 1'b0;

		while (expected_results.size() != 0)
			@(negedge clk);
		repeat (100) @(negedge clk);
		if (error_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
